/* rtl/core/dks_pkg.sv */
`timescale 1ns / 1ps

package dks_pkg;

    localparam int KEY_W        = 24;
    localparam int HANDLE_W     = 16;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic
    {
        ST_FILL,
        ST_DRAIN
    } dks_state_t;

    // Per-cycle command broadcast along the cell chain.
    typedef struct packed
    {
        logic insert;   // a new entry enters the chain this cycle
        logic shift;    // every cell takes its right neighbor's contents
    } dks_ctl_t;

endpackage

/* rtl/core/dks_in_if.sv */
`timescale 1ns / 1ps

interface dks_in_if;

    logic                          valid;
    logic                          ready;
    logic [dks_pkg::KEY_W-1:0]     distance;
    logic [dks_pkg::HANDLE_W-1:0]  handle;
    logic                          batch_end;

    modport source (output valid, output distance, output handle, output batch_end,
                    input ready);
    modport sink   (input valid, input distance, input handle, input batch_end,
                    output ready);

endinterface

/* rtl/core/dks_out_if.sv */
`timescale 1ns / 1ps

interface dks_out_if;

    logic                          valid;
    logic                          ready;
    logic [dks_pkg::HANDLE_W-1:0]  sorted_handle;
    logic [dks_pkg::KEY_W-1:0]     sorted_distance;
    logic                          final_entry;
    logic                          overflowed;

    modport source (output valid, output sorted_handle, output sorted_distance,
                    output final_entry, output overflowed, input ready);
    modport sink   (input valid, input sorted_handle, input sorted_distance,
                    input final_entry, input overflowed, output ready);

endinterface

/* rtl/core/dks_cell.sv */
`timescale 1ns / 1ps

module dks_cell
(
    input  logic                          clk,
    input  dks_pkg::dks_ctl_t             ctl,
    input  logic                          valid,
    input  logic [dks_pkg::KEY_W-1:0]     new_key,
    input  logic [dks_pkg::HANDLE_W-1:0]  new_handle,
    input  logic [dks_pkg::KEY_W-1:0]     left_key,
    input  logic [dks_pkg::HANDLE_W-1:0]  left_handle,
    input  logic                          left_gt,
    input  logic [dks_pkg::KEY_W-1:0]     right_key,
    input  logic [dks_pkg::HANDLE_W-1:0]  right_handle,
    output logic [dks_pkg::KEY_W-1:0]     key,
    output logic [dks_pkg::HANDLE_W-1:0]  handle,
    output logic                          gt
);
    import dks_pkg::*;

    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    key_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic                keep;

    // A valid entry whose key exceeds the new key moves one place right.
    assign gt   = valid && (key_reg > new_key);
    assign keep = valid && !gt;

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctl.shift)
        begin
            key_next    = right_key;
            handle_next = right_handle;
        end
        else if (ctl.insert && !keep)
        begin
            if (left_gt)
            begin
                key_next    = left_key;
                handle_next = left_handle;
            end
            else
            begin
                key_next    = new_key;
                handle_next = new_handle;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign key    = key_reg;
    assign handle = handle_reg;

endmodule

/* rtl/core/distance_key_insertion_sorter.sv */
`timescale 1ns / 1ps
// Output: the first sorted beat is offered in the cycle after the batch_end entry is
// accepted.
// Throughput: one entry per cycle while a batch fills; a batch of n stored entries then
// drains at one beat per cycle while result.ready is high, during which no entry is taken.
// Reset: rst_n clears the fill count, overflow flag and controller; stored keys are not reset.

module distance_key_insertion_sorter
#(
    parameter int CAPACITY = dks_pkg::CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    dks_in_if.sink     entry,
    dks_out_if.source  result
);
    import dks_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // The store is a chain of CAPACITY cells kept in ascending key order. Cells below
    // fill_reg hold entries; an insert compares the new key against every cell at once,
    // each larger entry steps one cell right, and the cell at the boundary takes the new
    // entry. Equal keys stay put, which keeps the sort stable.
    // Draining shifts the chain toward cell 0, which drives the output beat directly.

    dks_state_t           state_reg;
    dks_state_t           state_next;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic                 drop_reg;
    logic                 drop_next;
    dks_ctl_t             ctl;
    logic                 in_beat;
    logic                 out_beat;
    logic                 full;

    logic [KEY_W-1:0]     cell_key    [CAPACITY];
    logic [HANDLE_W-1:0]  cell_handle [CAPACITY];
    logic                 cell_gt     [CAPACITY];
    logic                 cell_valid  [CAPACITY];

    assign in_beat  = entry.valid && entry.ready;
    assign out_beat = result.valid && result.ready;
    assign full     = (fill_reg == CNT_W'(CAPACITY));

    assign ctl.insert = in_beat && !full;
    assign ctl.shift  = out_beat;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            assign cell_valid[i] = (CNT_W'(i) < fill_reg);

            if (i == 0)
            begin : g_first
                dks_cell u_cell
                (
                    .clk          (clk),
                    .ctl          (ctl),
                    .valid        (cell_valid[i]),
                    .new_key      (entry.distance),
                    .new_handle   (entry.handle),
                    .left_key     (entry.distance),
                    .left_handle  (entry.handle),
                    .left_gt      (1'b0),
                    .right_key    (cell_key[i+1]),
                    .right_handle (cell_handle[i+1]),
                    .key          (cell_key[i]),
                    .handle       (cell_handle[i]),
                    .gt           (cell_gt[i])
                );
            end
            else if (i == CAPACITY - 1)
            begin : g_last
                // Nothing lies to the right; after a shift this cell is past the fill.
                dks_cell u_cell
                (
                    .clk          (clk),
                    .ctl          (ctl),
                    .valid        (cell_valid[i]),
                    .new_key      (entry.distance),
                    .new_handle   (entry.handle),
                    .left_key     (cell_key[i-1]),
                    .left_handle  (cell_handle[i-1]),
                    .left_gt      (cell_gt[i-1]),
                    .right_key    (cell_key[i]),
                    .right_handle (cell_handle[i]),
                    .key          (cell_key[i]),
                    .handle       (cell_handle[i]),
                    .gt           (cell_gt[i])
                );
            end
            else
            begin : g_mid
                dks_cell u_cell
                (
                    .clk          (clk),
                    .ctl          (ctl),
                    .valid        (cell_valid[i]),
                    .new_key      (entry.distance),
                    .new_handle   (entry.handle),
                    .left_key     (cell_key[i-1]),
                    .left_handle  (cell_handle[i-1]),
                    .left_gt      (cell_gt[i-1]),
                    .right_key    (cell_key[i+1]),
                    .right_handle (cell_handle[i+1]),
                    .key          (cell_key[i]),
                    .handle       (cell_handle[i]),
                    .gt           (cell_gt[i])
                );
            end
        end
    endgenerate

    // Controller: entries are taken while filling; the batch_end entry is inserted (or dropped
    // if the store is full) and then the run drains, counting fill_reg down to zero.
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        drop_next    = drop_reg;
        entry.ready  = 1'b0;
        result.valid = 1'b0;
        unique case (state_reg)
            ST_FILL:
            begin
                entry.ready = 1'b1;
                if (in_beat)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (entry.batch_end)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                result.valid = 1'b1;
                if (out_beat)
                begin
                    fill_next = fill_reg - 1'b1;
                    if (result.final_entry)
                    begin
                        drop_next  = 1'b0;
                        state_next = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
        end
    end

    assign result.sorted_handle   = cell_handle[0];
    assign result.sorted_distance = cell_key[0];
    assign result.final_entry     = (fill_reg == CNT_W'(1));
    assign result.overflowed      = drop_reg;

    // A beat is only offered while the store holds at least one entry.
    a_beat_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (fill_reg != '0))
        else $error("output beat offered from an empty store");

    // The final beat of a run leaves the store empty and the overflow flag clear.
    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && result.final_entry) |=> ((fill_reg == '0) && !drop_reg))
        else $error("store not cleared after final beat");

    // An entry taken with room to spare grows the store by exactly one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !full) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not follow an insert");

    // The head of the chain never holds a larger key than its neighbor while draining.
    a_head_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN) && (fill_reg > CNT_W'(1))) |-> (cell_key[0] <= cell_key[1]))
        else $error("chain out of order during drain");

endmodule

/* verif/distance_key_insertion_sorter_tb.sv */
`timescale 1ns / 1ps

// One beat of the sorted run as the block should present it.
typedef struct packed
{
    logic [dks_pkg::HANDLE_W-1:0] handle;
    logic [dks_pkg::KEY_W-1:0]    distance;
    logic                         final_entry;
    logic                         overflowed;
} sorted_beat_t;

// Shadow copy of the sorter. Every accepted entry that finds room is placed into a
// local sorted store; a batch end turns the store into a list of expected output beats.
class sort_scoreboard;

    logic [dks_pkg::KEY_W-1:0]    shadow_keys [dks_pkg::CAPACITY_DEF];
    logic [dks_pkg::HANDLE_W-1:0] shadow_tags [dks_pkg::CAPACITY_DEF];
    int unsigned                  stored;
    bit                           dropped;
    sorted_beat_t                 expected_beats [$];
    int unsigned                  errors;

    function new();
        stored  = 0;
        dropped = 1'b0;
        errors  = 0;
    endfunction

    function int unsigned pending();
        return expected_beats.size();
    endfunction

    // Stable insertion: the new entry lands behind every key that is less than
    // or equal to its own. When the store is full the entry is lost.
    function void take_entry(input logic [dks_pkg::KEY_W-1:0] key_val,
                             input logic [dks_pkg::HANDLE_W-1:0] tag,
                             input logic last);
        int unsigned  slot;
        sorted_beat_t beat;
        if (stored < dks_pkg::CAPACITY_DEF)
        begin
            slot = stored;
            while (slot > 0 && shadow_keys[slot-1] > key_val)
            begin
                shadow_keys[slot] = shadow_keys[slot-1];
                shadow_tags[slot] = shadow_tags[slot-1];
                slot--;
            end
            shadow_keys[slot] = key_val;
            shadow_tags[slot] = tag;
            stored++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (last)
        begin
            for (int unsigned k = 0; k < stored; k++)
            begin
                beat.handle      = shadow_tags[k];
                beat.distance    = shadow_keys[k];
                beat.final_entry = (k + 1 == stored);
                beat.overflowed  = dropped;
                expected_beats   = {expected_beats, beat};
            end
            stored  = 0;
            dropped = 1'b0;
        end
    endfunction

    function void match_beat(input logic [dks_pkg::HANDLE_W-1:0] tag,
                             input logic [dks_pkg::KEY_W-1:0] key_val,
                             input logic fin,
                             input logic ovf);
        sorted_beat_t want;
        if (expected_beats.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected beat handle %h distance %h final %b overflowed %b",
                     $time, tag, key_val, fin, ovf);
            return;
        end
        want = expected_beats.pop_front();
        if (tag !== want.handle)
        begin
            errors++;
            $display("%0t: sorted_handle expected %h actual %h", $time, want.handle, tag);
        end
        if (key_val !== want.distance)
        begin
            errors++;
            $display("%0t: sorted_distance expected %h actual %h",
                     $time, want.distance, key_val);
        end
        if (fin !== want.final_entry)
        begin
            errors++;
            $display("%0t: final_entry expected %b actual %b", $time, want.final_entry, fin);
        end
        if (ovf !== want.overflowed)
        begin
            errors++;
            $display("%0t: overflowed expected %b actual %b", $time, want.overflowed, ovf);
        end
    endfunction

endclass

module distance_key_insertion_sorter_tb;

    import dks_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 215;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 20;

    // How the keys of one random batch are drawn.
    typedef enum int
    {
        KEYS_WIDE,
        KEYS_CLUSTERED,
        KEYS_EDGE
    } key_mix_t;

    logic clk;
    logic rst_n;

    dks_in_if  entry_if ();
    dks_out_if result_if ();

    sort_scoreboard board = new();

    // hold_request and quiet are shared between the entry driver and the result sink.
    // hold_request asks the sink for one long back-pressure stretch; quiet turns all idling off.
    bit hold_request = 1'b0;
    bit quiet        = 1'b0;
    bit gaps_on      = 1'b1;
    int unsigned cycle_cnt = 0;

    distance_key_insertion_sorter #(
        .CAPACITY (DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .entry  (entry_if),
        .result (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The watchdog. The limit is meant to fire only if the block hangs.
    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("distance_key_insertion_sorter_tb failed");
        $finish;
    end

    function automatic logic [KEY_W-1:0] pick_key(input key_mix_t mix);
        logic [KEY_W-1:0] k;
        case (mix)
            KEYS_WIDE:      k = KEY_W'($urandom);
            KEYS_CLUSTERED: k = KEY_W'($urandom_range(0, 7));
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       k = '0;
                    1:       k = KEY_W'(1);
                    2:       k = {KEY_W{1'b1}} - 1'b1;
                    default: k = {KEY_W{1'b1}};
                endcase
            end
        endcase
        return k;
    endfunction

    // Offers one entry beat and waits until the block takes it. The task is
    // entered right after a rising edge, so the assignments below land on that
    // edge. The ready value read after each edge is the one the edge sampled.
    task automatic send_entry(input logic [KEY_W-1:0] key_val,
                              input logic [HANDLE_W-1:0] tag,
                              input logic last);
        if (gaps_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            entry_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        entry_if.valid     <= 1'b1;
        entry_if.distance  <= key_val;
        entry_if.handle    <= tag;
        entry_if.batch_end <= last;
        do
            @(posedge clk);
        while (!entry_if.ready);
        board.take_entry(key_val, tag, last);
    endtask

    // Stops offering entries until every predicted beat has been seen.
    task automatic wait_drained();
        entry_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Result sink. It checks every accepted beat and then chooses the next value
    // of ready: a long hold when the driver asks for one, otherwise short random
    // stalls during phases where idling is on and quiet is off. phase_cnt redraws
    // the phase at random, so some stretches run with ready held high.
    initial
    begin : result_sink
        int  stall_left;
        int  hold_left;
        int  phase_cnt;
        bit  idle_on;
        stall_left = 0;
        hold_left  = 0;
        phase_cnt  = 0;
        idle_on    = 1'b1;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
                board.match_beat(result_if.sorted_handle, result_if.sorted_distance,
                                 result_if.final_entry, result_if.overflowed);
            phase_cnt++;
            if (phase_cnt % 64 == 0)
                idle_on = ($urandom_range(0, 1) == 1);
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                result_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (!quiet && idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin : entry_driver
        int unsigned sent;
        int unsigned batch_no;
        int unsigned batch_len;
        key_mix_t    mix;
        sent     = 0;
        batch_no = 0;

        rst_n              <= 1'b0;
        entry_if.valid     <= 1'b0;
        entry_if.distance  <= '0;
        entry_if.handle    <= '0;
        entry_if.batch_end <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A batch of one entry, with both fields at their maximum.
        send_entry({KEY_W{1'b1}}, {HANDLE_W{1'b1}}, 1'b1);

        // Extremes and a run of equal keys: the three entries with key 5 must
        // come out in arrival order, and the closing entry ties with the largest
        // stored key, so it must land behind it.
        send_entry('0, '0, 1'b0);
        send_entry({KEY_W{1'b1}}, {HANDLE_W{1'b1}}, 1'b0);
        send_entry(24'd5, 16'h0001, 1'b0);
        send_entry(24'd5, 16'h0002, 1'b0);
        send_entry(24'd5, 16'h0003, 1'b0);
        send_entry('0, 16'h0004, 1'b0);
        send_entry({KEY_W{1'b1}}, 16'h0005, 1'b1);

        // Strictly descending keys: every new entry moves to the front.
        send_entry(24'h800000, 16'h8000, 1'b0);
        send_entry(24'h400000, 16'h4000, 1'b0);
        send_entry(24'h000100, 16'h0100, 1'b0);
        send_entry(24'h000001, 16'h0001, 1'b1);

        // The closing entry carries the smallest key and must lead the run.
        send_entry(24'd10, 16'h0a0a, 1'b0);
        send_entry(24'd20, 16'h1414, 1'b0);
        send_entry(24'd30, 16'h1e1e, 1'b0);
        send_entry(24'd0, 16'hffff, 1'b1);

        // Two zero keys with complementary handles.
        send_entry('0, 16'haaaa, 1'b0);
        send_entry('0, 16'h5555, 1'b1);

        wait_drained();

        // Random batches. Most are short; one overflows the store, with dropped
        // entries both without and with the batch end mark, and one fills the
        // store exactly. When the third batch starts, the sink holds ready low
        // for a long time while the driver keeps offering entries, so the block
        // has to stall its input.
        while (sent < RANDOM_ITEMS)
        begin
            batch_no++;
            if (batch_no == 5)
                batch_len = DEPTH + 3;
            else if (batch_no == 9)
                batch_len = DEPTH;
            else if ($urandom_range(0, 4) == 0)
                batch_len = 1;
            else
                batch_len = $urandom_range(2, 12);
            mix     = key_mix_t'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            if (batch_no == 3)
                hold_request = 1'b1;
            // The tail of the run goes without idling on either side.
            if (!quiet && sent + 40 >= RANDOM_ITEMS)
            begin
                wait_drained();
                quiet = 1'b1;
            end
            for (int unsigned i = 0; i < batch_len; i++)
            begin
                send_entry(pick_key(mix), HANDLE_W'($urandom), i + 1 == batch_len);
                sent++;
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("distance_key_insertion_sorter_tb passed");
        else
            $display("distance_key_insertion_sorter_tb failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/dks_pkg.sv
rtl/core/dks_in_if.sv
rtl/core/dks_out_if.sv
rtl/core/dks_cell.sv
rtl/core/distance_key_insertion_sorter.sv
verif/distance_key_insertion_sorter_tb.sv
